>>> rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate: shared package
// Widths, word types and the rounding and saturation helpers that the
// matrix and rotation stages share.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // Field widths of the input and result words.
    localparam int VEC_WIDTH  = 16;
    localparam int QUAT_WIDTH = 16;

    // Quaternion parts and matrix terms are Q2.QFRAC.
    localparam int QFRAC = QUAT_WIDTH - 2;

    // A product of two quaternion parts, and a sum of four such products.
    localparam int PROD_W = 2 * QUAT_WIDTH;
    localparam int TERM_W = PROD_W + 2;

    // A wind part times a matrix term, and a sum of three such products.
    localparam int RPROD_W = VEC_WIDTH + QUAT_WIDTH;
    localparam int ROW_W   = RPROD_W + 2;

    // Number of rotation matrix terms.
    localparam int NUM_TERMS = 9;

    typedef logic signed [VEC_WIDTH-1:0]  vec_t;
    typedef logic signed [QUAT_WIDTH-1:0] quat_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [TERM_W-1:0]     term_t;
    typedef logic signed [RPROD_W-1:0]    rprod_t;
    typedef logic signed [ROW_W-1:0]      row_t;

    // Rounding offsets and saturation limits, held one bit wider than the
    // sums they apply to so that the half-unit add cannot overflow.
    localparam logic signed [TERM_W:0] TERM_HALF =
        (TERM_W + 1)'(64'sd1 <<< (QFRAC - 1));
    localparam logic signed [TERM_W:0] TERM_HI =
        (TERM_W + 1)'((64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [TERM_W:0] TERM_LO = -TERM_HI - 1;

    localparam logic signed [ROW_W:0] ROW_HALF =
        (ROW_W + 1)'(64'sd1 <<< (QFRAC - 1));
    localparam logic signed [ROW_W:0] ROW_HI =
        (ROW_W + 1)'((64'sd1 <<< (VEC_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ROW_W:0] ROW_LO = -ROW_HI - 1;

    // Largest and smallest result values.
    localparam vec_t VEC_MAX = VEC_WIDTH'(ROW_HI);
    localparam vec_t VEC_MIN = VEC_WIDTH'(ROW_LO);

    // Input word: body-frame wind and attitude quaternion.
    typedef struct packed {
        logic signed [VEC_WIDTH-1:0]  wind_u;
        logic signed [VEC_WIDTH-1:0]  wind_v;
        logic signed [VEC_WIDTH-1:0]  wind_w;
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } qvr_in_t;

    // Result word: earth-frame wind and the saturation flag.
    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] earth_u;
        logic signed [VEC_WIDTH-1:0] earth_v;
        logic signed [VEC_WIDTH-1:0] earth_w;
        logic                        clipped;
    } qvr_out_t;

    // Wind vector carried alongside the matrix computation.
    typedef struct packed {
        vec_t u;
        vec_t v;
        vec_t w;
    } qvr_wind_t;

    // Word passed from the matrix stages to the rotation stages.
    // Terms are row-major: r[0] = r00, r[1] = r01, ... r[8] = r22.
    typedef struct packed {
        qvr_wind_t                  wind;
        quat_t [NUM_TERMS-1:0]      r;
    } qvr_mat_t;

    // A rounded result component and whether it was saturated.
    typedef struct packed {
        logic hit;
        vec_t value;
    } qvr_sat_t;

    // Round a matrix term to QFRAC fraction bits (half up) and saturate it
    // to the quaternion range. Saturation here is silent.
    function automatic quat_t term_round(input term_t acc);
        logic signed [TERM_W:0] sum;
        logic signed [TERM_W:0] sh;
        quat_t                  res;
        sum = {acc[TERM_W-1], acc} + TERM_HALF;
        sh  = sum >>> QFRAC;
        if (sh > TERM_HI)
            res = QUAT_WIDTH'(TERM_HI);
        else if (sh < TERM_LO)
            res = QUAT_WIDTH'(TERM_LO);
        else
            res = QUAT_WIDTH'(sh);
        return res;
    endfunction

    // Round a row sum to whole output units (half up) and saturate it to
    // the result range, reporting any saturation.
    function automatic qvr_sat_t row_round(input row_t acc);
        logic signed [ROW_W:0] sum;
        logic signed [ROW_W:0] sh;
        qvr_sat_t              res;
        sum = {acc[ROW_W-1], acc} + ROW_HALF;
        sh  = sum >>> QFRAC;
        if (sh > ROW_HI)
        begin
            res.hit   = 1'b1;
            res.value = VEC_MAX;
        end
        else if (sh < ROW_LO)
        begin
            res.hit   = 1'b1;
            res.value = VEC_MIN;
        end
        else
        begin
            res.hit   = 1'b0;
            res.value = VEC_WIDTH'(sh);
        end
        return res;
    endfunction

endpackage

>>> rtl/qvr_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate: rotation matrix stages
// Three pipeline stages that turn a quaternion into the nine Q2.14 terms of
// its rotation matrix, carrying the wind vector alongside.
// ----------------------------------------------------------------------------
module qvr_matrix
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qvr_pkg::qvr_in_t  in_word,
    output logic              out_valid,
    output qvr_pkg::qvr_mat_t out_word
);

    // Stage 1: the ten products of quaternion parts.
    logic                v1_reg;
    qvr_pkg::qvr_wind_t  wind1_reg;
    qvr_pkg::prod_t      aa_reg, bb_reg, cc_reg, dd_reg;
    qvr_pkg::prod_t      ab_reg, ac_reg, ad_reg;
    qvr_pkg::prod_t      bc_reg, bd_reg, cd_reg;

    // Stage 2: exact matrix term sums.
    logic                v2_reg;
    qvr_pkg::qvr_wind_t  wind2_reg;
    qvr_pkg::term_t      sum2_reg [qvr_pkg::NUM_TERMS];
    qvr_pkg::term_t      sum2_next [qvr_pkg::NUM_TERMS];

    // Stage 3: rounded and saturated terms.
    logic                v3_reg;
    qvr_pkg::qvr_mat_t   mat3_reg;
    qvr_pkg::qvr_mat_t   mat3_next;

    // Valid bits travel with the data and are the only state under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 products, each operand sign-extended to the product width.
    always_ff @(posedge clk)
    begin
        wind1_reg.u <= in_word.wind_u;
        wind1_reg.v <= in_word.wind_v;
        wind1_reg.w <= in_word.wind_w;
        aa_reg <= qvr_pkg::prod_t'(in_word.quat_w) * qvr_pkg::prod_t'(in_word.quat_w);
        bb_reg <= qvr_pkg::prod_t'(in_word.quat_x) * qvr_pkg::prod_t'(in_word.quat_x);
        cc_reg <= qvr_pkg::prod_t'(in_word.quat_y) * qvr_pkg::prod_t'(in_word.quat_y);
        dd_reg <= qvr_pkg::prod_t'(in_word.quat_z) * qvr_pkg::prod_t'(in_word.quat_z);
        ab_reg <= qvr_pkg::prod_t'(in_word.quat_w) * qvr_pkg::prod_t'(in_word.quat_x);
        ac_reg <= qvr_pkg::prod_t'(in_word.quat_w) * qvr_pkg::prod_t'(in_word.quat_y);
        ad_reg <= qvr_pkg::prod_t'(in_word.quat_w) * qvr_pkg::prod_t'(in_word.quat_z);
        bc_reg <= qvr_pkg::prod_t'(in_word.quat_x) * qvr_pkg::prod_t'(in_word.quat_y);
        bd_reg <= qvr_pkg::prod_t'(in_word.quat_x) * qvr_pkg::prod_t'(in_word.quat_z);
        cd_reg <= qvr_pkg::prod_t'(in_word.quat_y) * qvr_pkg::prod_t'(in_word.quat_z);
    end

    // Stage 2 sums: diagonal terms are signed sums of four squares, the others are
    // twice a sum or difference of two cross products.
    always_comb
    begin
        sum2_next[0] = qvr_pkg::term_t'(aa_reg) + qvr_pkg::term_t'(bb_reg)
                     - qvr_pkg::term_t'(cc_reg) - qvr_pkg::term_t'(dd_reg);
        sum2_next[1] = (qvr_pkg::term_t'(bc_reg) - qvr_pkg::term_t'(ad_reg)) <<< 1;
        sum2_next[2] = (qvr_pkg::term_t'(bd_reg) + qvr_pkg::term_t'(ac_reg)) <<< 1;
        sum2_next[3] = (qvr_pkg::term_t'(bc_reg) + qvr_pkg::term_t'(ad_reg)) <<< 1;
        sum2_next[4] = qvr_pkg::term_t'(aa_reg) - qvr_pkg::term_t'(bb_reg)
                     + qvr_pkg::term_t'(cc_reg) - qvr_pkg::term_t'(dd_reg);
        sum2_next[5] = (qvr_pkg::term_t'(cd_reg) - qvr_pkg::term_t'(ab_reg)) <<< 1;
        sum2_next[6] = (qvr_pkg::term_t'(bd_reg) - qvr_pkg::term_t'(ac_reg)) <<< 1;
        sum2_next[7] = (qvr_pkg::term_t'(cd_reg) + qvr_pkg::term_t'(ab_reg)) <<< 1;
        sum2_next[8] = qvr_pkg::term_t'(aa_reg) - qvr_pkg::term_t'(bb_reg)
                     - qvr_pkg::term_t'(cc_reg) + qvr_pkg::term_t'(dd_reg);
    end

    always_ff @(posedge clk)
    begin
        wind2_reg <= wind1_reg;
        sum2_reg  <= sum2_next;
    end

    // Stage 3: round each term to Q2.14 and clamp it.
    always_comb
    begin
        mat3_next.wind = wind2_reg;
        for (int i = 0; i < qvr_pkg::NUM_TERMS; i++)
        begin
            mat3_next.r[i] = qvr_pkg::term_round(sum2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        mat3_reg <= mat3_next;
    end

    assign out_valid = v3_reg;
    assign out_word  = mat3_reg;

endmodule

>>> rtl/qvr_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate: vector rotation stages
// Three pipeline stages that multiply the wind vector by the rotation
// matrix, then round and saturate each earth-frame component.
// ----------------------------------------------------------------------------
module qvr_rotate
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qvr_pkg::qvr_mat_t in_word,
    output logic              out_valid,
    output qvr_pkg::qvr_out_t out_word
);

    // Stage 4: nine wind-by-term products.
    logic                v4_reg;
    qvr_pkg::rprod_t     prod4_reg [qvr_pkg::NUM_TERMS];
    qvr_pkg::rprod_t     prod4_next [qvr_pkg::NUM_TERMS];

    // Stage 5: the three row sums.
    logic                v5_reg;
    qvr_pkg::row_t       row5_reg [3];
    qvr_pkg::row_t       row5_next [3];

    // Stage 6: output register.
    logic                v6_reg;
    qvr_pkg::qvr_out_t   res6_reg;
    qvr_pkg::qvr_out_t   res6_next;
    qvr_pkg::qvr_sat_t   sat_u, sat_v, sat_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Each matrix row multiplies u, v and w in turn.
    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            prod4_next[3*row]     = qvr_pkg::rprod_t'(in_word.wind.u)
                                  * qvr_pkg::rprod_t'(in_word.r[3*row]);
            prod4_next[3*row + 1] = qvr_pkg::rprod_t'(in_word.wind.v)
                                  * qvr_pkg::rprod_t'(in_word.r[3*row + 1]);
            prod4_next[3*row + 2] = qvr_pkg::rprod_t'(in_word.wind.w)
                                  * qvr_pkg::rprod_t'(in_word.r[3*row + 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod4_reg <= prod4_next;
    end

    // Exact row sums.
    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            row5_next[row] = qvr_pkg::row_t'(prod4_reg[3*row])
                           + qvr_pkg::row_t'(prod4_reg[3*row + 1])
                           + qvr_pkg::row_t'(prod4_reg[3*row + 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        row5_reg <= row5_next;
    end

    // Round to whole units, saturate, and gather the clip flag.
    always_comb
    begin
        sat_u = qvr_pkg::row_round(row5_reg[0]);
        sat_v = qvr_pkg::row_round(row5_reg[1]);
        sat_w = qvr_pkg::row_round(row5_reg[2]);
        res6_next.earth_u = sat_u.value;
        res6_next.earth_v = sat_v.value;
        res6_next.earth_w = sat_w.value;
        res6_next.clipped = sat_u.hit | sat_v.hit | sat_w.hit;
    end

    always_ff @(posedge clk)
    begin
        res6_reg <= res6_next;
    end

    assign out_valid = v6_reg;
    assign out_word  = res6_reg;

endmodule

>>> rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// A word is taken on an edge with start high and passes through the register stages below;
// done rises as its result leaves the output rounding stage.
// Throughput: one word per cycle; six register stages (quaternion products, term sums,
// term rounding, wind products, row sums, output rounding) each hold one word.
// busy stays low: results are not held back, each shows on done for exactly one cycle.
// Reset clears the stage valid bits only, so words in flight at reset are dropped.
// ----------------------------------------------------------------------------
// Quaternion vector rotate: top level
// Rotates a body-frame wind vector into the earth frame using the rotation
// matrix of an attitude quaternion, with rounding and output saturation.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  qvr_pkg::qvr_in_t  sample,
    output logic              done,
    output qvr_pkg::qvr_out_t result
);

    localparam int LATENCY = 6;

    logic              mat_valid;
    qvr_pkg::qvr_mat_t mat_word;
    logic              accept;

    // The pipeline never stalls, so a word is taken on every start.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Rotation matrix from the quaternion.
    qvr_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_word   (sample),
        .out_valid (mat_valid),
        .out_word  (mat_word)
    );

    // Wind vector times the matrix, rounded and saturated.
    qvr_rotate u_rotate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_word   (mat_word),
        .out_valid (done),
        .out_word  (result)
    );

    // Every accepted word gives a result on done.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word produced no result");

    // No result appears without a matching accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching accepted word");

    // The clip flag means at least one component sits at a range limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.clipped) |->
            (result.earth_u == qvr_pkg::VEC_MAX || result.earth_u == qvr_pkg::VEC_MIN ||
             result.earth_v == qvr_pkg::VEC_MAX || result.earth_v == qvr_pkg::VEC_MIN ||
             result.earth_w == qvr_pkg::VEC_MAX || result.earth_w == qvr_pkg::VEC_MIN))
        else $error("clipped set with no saturated component");

endmodule
